FILE: hdl/plist_pkg.sv
package plist_pkg;

   localparam int CAPACITY_DEFAULT = 1024;
   // wide enough for any cell index up to the largest supported capacity
   localparam int CELL_IDX_W = 16;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_APPEND = 3'd3;
   localparam logic [2:0] OP_ROTATE = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef logic signed [31:0] entry_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [10:0] position;
      entry_type   value;
      logic        direction;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      entry_type   read_value;
      logic [10:0] entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      CM_HOLD,
      CM_INSERT,
      CM_DELETE,
      CM_ROTATE
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type           mode;
      logic [CELL_IDX_W-1:0]   pin;
      logic [CELL_IDX_W-1:0]   last;
      entry_type               value;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_PEND
   } state_type;

endpackage

FILE: hdl/plist_cell.sv
module plist_cell #(
   parameter int INDEX = 0
) (
   input  logic                    clock,
   input  plist_pkg::cell_ctrl_type ctrl,
   input  plist_pkg::entry_type    left_data,
   input  plist_pkg::entry_type    right_data,
   input  plist_pkg::entry_type    head_data,
   output plist_pkg::entry_type    cell_data
);

   localparam logic [plist_pkg::CELL_IDX_W-1:0] MY_IDX = plist_pkg::CELL_IDX_W'(INDEX);

   plist_pkg::entry_type data_ff;
   plist_pkg::entry_type data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.mode)
         plist_pkg::CM_INSERT: begin
            if (MY_IDX == ctrl.pin) begin
               data_in = ctrl.value;
            end else if (MY_IDX > ctrl.pin) begin
               data_in = left_data;
            end
         end
         plist_pkg::CM_DELETE: begin
            if (MY_IDX >= ctrl.pin) begin
               data_in = right_data;
            end
         end
         plist_pkg::CM_ROTATE: begin
            // one step left within the live entries; the head wraps to the tail
            if (MY_IDX == ctrl.last) begin
               data_in = head_data;
            end else if (MY_IDX < ctrl.last) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_data = data_ff;

endmodule

FILE: hdl/positional_list_engine.sv
// Sequencing: insert, delete, append and rejected words go straight to the pending state;
// read, and a rotate that is not a no-op, first walk the cell row and then pend.
// Throughput: one request in flight; the rotate/read walk moves the cell row one
// place per cycle, and the pending state waits for a free response slot.
// Reset (synchronous): clears the entry count, sequencer and response valid; the
// cell contents are not cleared.
module positional_list_engine #(
   parameter int CAPACITY = plist_pkg::CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  plist_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output plist_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > 11) ? CNT_W : 11) + 1;
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

   plist_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     step_ff, step_in;
   logic [CNT_W-1:0]     steps_ff, steps_in;
   logic [CNT_W-1:0]     target_ff, target_in;
   logic                 rd_walk_ff, rd_walk_in;
   plist_pkg::rsp_type   pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   plist_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic accept;
   logic slot_free;
   logic walk_last;

   logic [CMP_W-1:0]              pos_c;
   logic [CMP_W-1:0]              cnt_c;
   logic [CMP_W-1:0]              amt_c;
   logic [1:0]                    dec_status;
   plist_pkg::cell_mode_type      dec_mode;
   logic [plist_pkg::CELL_IDX_W-1:0] dec_pin;
   logic [CNT_W-1:0]              dec_count;
   logic                          dec_walk;
   logic                          dec_read;
   logic [CNT_W-1:0]              dec_steps;

   plist_pkg::cell_ctrl_type ctrl;
   plist_pkg::entry_type     cell_q [CAPACITY];

   assign req_stall = (state_ff != plist_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign walk_last = (step_ff == steps_ff - 1'b1);

   // request decode against the current count
   always_comb begin
      pos_c      = CMP_W'(req_data.position);
      cnt_c      = CMP_W'(count_ff);
      amt_c      = req_data.direction ? (cnt_c - pos_c) : pos_c;
      dec_status = plist_pkg::STATUS_OK;
      dec_mode   = plist_pkg::CM_HOLD;
      dec_pin    = plist_pkg::CELL_IDX_W'(pos_c - 1'b1);
      dec_count  = count_ff;
      dec_walk   = 1'b0;
      dec_read   = 1'b0;
      dec_steps  = count_ff;
      case (req_data.opcode)
         plist_pkg::OP_INSERT: begin
            if (count_ff == CAP_C) begin
               dec_status = plist_pkg::STATUS_FULL;
            end else if (pos_c == '0 || pos_c > cnt_c + 1'b1) begin
               dec_status = plist_pkg::STATUS_RANGE;
            end else begin
               dec_mode  = plist_pkg::CM_INSERT;
               dec_count = count_ff + 1'b1;
            end
         end
         plist_pkg::OP_DELETE: begin
            if (pos_c == '0 || pos_c > cnt_c) begin
               dec_status = plist_pkg::STATUS_RANGE;
            end else begin
               dec_mode  = plist_pkg::CM_DELETE;
               dec_count = count_ff - 1'b1;
            end
         end
         plist_pkg::OP_READ: begin
            if (pos_c == '0 || pos_c > cnt_c) begin
               dec_status = plist_pkg::STATUS_RANGE;
            end else begin
               // full turn of the live entries, tapping the head on the way past
               dec_walk = 1'b1;
               dec_read = 1'b1;
            end
         end
         plist_pkg::OP_APPEND: begin
            if (count_ff == CAP_C) begin
               dec_status = plist_pkg::STATUS_FULL;
            end else begin
               dec_mode  = plist_pkg::CM_INSERT;
               dec_pin   = plist_pkg::CELL_IDX_W'(count_ff);
               dec_count = count_ff + 1'b1;
            end
         end
         plist_pkg::OP_ROTATE: begin
            if (pos_c > cnt_c) begin
               dec_status = plist_pkg::STATUS_RANGE;
            end else begin
               dec_walk  = !(amt_c == '0 || amt_c == cnt_c);
               dec_steps = CNT_W'(amt_c);
            end
         end
         default: begin
            dec_status = plist_pkg::STATUS_RANGE;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plist_pkg::S_IDLE: begin
            if (accept) begin
               state_in = dec_walk ? plist_pkg::S_WALK : plist_pkg::S_PEND;
            end
         end
         plist_pkg::S_WALK: begin
            if (walk_last) begin
               state_in = plist_pkg::S_PEND;
            end
         end
         plist_pkg::S_PEND: begin
            if (slot_free) begin
               state_in = plist_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = plist_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and cell control
   always_comb begin
      count_in     = count_ff;
      step_in      = step_ff;
      steps_in     = steps_ff;
      target_in    = target_ff;
      rd_walk_in   = rd_walk_ff;
      pend_in      = pend_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctrl.mode    = plist_pkg::CM_HOLD;
      ctrl.pin     = dec_pin;
      ctrl.last    = plist_pkg::CELL_IDX_W'(count_ff) - 1'b1;
      ctrl.value   = req_data.value;
      case (state_ff)
         plist_pkg::S_IDLE: begin
            if (accept) begin
               ctrl.mode           = dec_mode;
               count_in            = dec_count;
               step_in             = '0;
               steps_in            = dec_steps;
               target_in           = CNT_W'(pos_c - 1'b1);
               rd_walk_in          = dec_read;
               pend_in.status      = dec_status;
               pend_in.read_value  = '0;
               pend_in.entry_count = 11'(dec_count);
            end
         end
         plist_pkg::S_WALK: begin
            ctrl.mode = plist_pkg::CM_ROTATE;
            step_in   = step_ff + 1'b1;
            if (rd_walk_ff && step_ff == target_ff) begin
               pend_in.read_value = cell_q[0];
            end
         end
         plist_pkg::S_PEND: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
            end
         end
         default: begin
            ctrl.mode = plist_pkg::CM_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plist_pkg::S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         steps_ff     <= '0;
         rd_walk_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         steps_ff     <= steps_in;
         rd_walk_ff   <= rd_walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         plist_pkg::entry_type left_w;
         plist_pkg::entry_type right_w;
         if (g == 0) begin : g_first
            assign left_w = '0;
         end else begin : g_left
            assign left_w = cell_q[g-1];
         end
         if (g == CAPACITY - 1) begin : g_tail
            assign right_w = '0;
         end else begin : g_right
            assign right_w = cell_q[g+1];
         end
         plist_cell #(
            .INDEX(g)
         ) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .left_data (left_w),
            .right_data(right_w),
            .head_data (cell_q[0]),
            .cell_data (cell_q[g])
         );
      end
   endgenerate

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/plist_checker.sv
module plist_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input plist_pkg::rsp_type rsp_data
);

   // a stalled response word must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // one request at a time: an accepted word closes the input next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in flight");

   // only a successful read carries data
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != plist_pkg::STATUS_OK |-> rsp_data.read_value == '0)
      else $error("read value on a failed request");

   // a full store cannot report an empty list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == plist_pkg::STATUS_FULL |-> rsp_data.entry_count != '0)
      else $error("store full reported with zero entries");

endmodule

bind positional_list_engine plist_checker u_plist_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

FILE: sim/positional_list_checker.sv
module positional_list_checker #(
   parameter int CAPACITY = plist_pkg::CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  plist_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  plist_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 words_checked,
   output int                 pending
);

   plist_pkg::entry_type list_mem [CAPACITY];
   plist_pkg::entry_type scratch  [CAPACITY];
   int                   list_len;
   plist_pkg::rsp_type   expected_rsp [$];

   function automatic plist_pkg::rsp_type apply_request(input plist_pkg::req_type w);
      plist_pkg::rsp_type r;
      int      p;
      int      shift;
      int      i;
      r = '0;
      r.status = plist_pkg::STATUS_OK;
      p = int'(w.position);
      case (w.opcode)
         plist_pkg::OP_INSERT: begin
            if (list_len >= CAPACITY) begin
               r.status = plist_pkg::STATUS_FULL;
            end else if (p < 1 || p > list_len + 1) begin
               r.status = plist_pkg::STATUS_RANGE;
            end else begin
               for (i = list_len; i > p - 1; i--) list_mem[i] = list_mem[i - 1];
               list_mem[p - 1] = w.value;
               list_len++;
            end
         end
         plist_pkg::OP_DELETE: begin
            if (p < 1 || p > list_len) begin
               r.status = plist_pkg::STATUS_RANGE;
            end else begin
               for (i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
               list_len--;
            end
         end
         plist_pkg::OP_READ: begin
            if (p < 1 || p > list_len) r.status = plist_pkg::STATUS_RANGE;
            else r.read_value = list_mem[p - 1];
         end
         plist_pkg::OP_APPEND: begin
            if (list_len >= CAPACITY) begin
               r.status = plist_pkg::STATUS_FULL;
            end else begin
               list_mem[list_len] = w.value;
               list_len++;
            end
         end
         plist_pkg::OP_ROTATE: begin
            if (p > list_len) begin
               r.status = plist_pkg::STATUS_RANGE;
            end else if (list_len > 0) begin
               // right by n is left by len-n; left by 0 or len is a no-op via the modulo
               shift = w.direction ? list_len - p : p;
               for (i = 0; i < list_len; i++) scratch[i] = list_mem[(i + shift) % list_len];
               for (i = 0; i < list_len; i++) list_mem[i] = scratch[i];
            end
         end
         default: r.status = plist_pkg::STATUS_RANGE;
      endcase
      r.entry_count = 11'(list_len);
      return r;
   endfunction

   always @(posedge clock) begin
      plist_pkg::rsp_type got;
      plist_pkg::rsp_type want;
      if (reset) begin
         list_len = 0;
         expected_rsp.delete();
      end else begin
         if (req_valid && !req_stall) expected_rsp = {expected_rsp, apply_request(req_data)};
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expected_rsp.size() == 0) begin
               $error("response word with none expected: status %0d, count %0d",
                      got.status, got.entry_count);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               words_checked++;
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value,
                         got.read_value);
                  fail_count++;
               end
               if (got.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d", want.entry_count,
                         got.entry_count);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_rsp.size();
   end

endmodule

FILE: sim/tb_positional_list_engine.sv
module tb_positional_list_engine;

   localparam int CAP = plist_pkg::CAPACITY_DEFAULT;
   // opcodes with no operation behind them
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   plist_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   plist_pkg::rsp_type rsp_data;

   int fail_count;
   int words_checked;
   int pending;
   int words_sent;
   int shadow_len;
   int peak_len;
   int op_tally [8];
   bit idle_on;

   positional_list_engine #(.CAPACITY(CAP)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   positional_list_checker #(.CAPACITY(CAP)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .words_checked (words_checked),
      .pending       (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #40_000_000;
      $display("positional_list_engine test failed");
      $finish;
   end

   // receiver stalls in bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic plist_pkg::req_type make_word(input logic [2:0] op, input int pos,
                                                    input plist_pkg::entry_type val,
                                                    input logic dir);
      plist_pkg::req_type w;
      w.opcode    = op;
      w.position  = 11'(pos);
      w.value     = val;
      w.direction = dir;
      return w;
   endfunction

   // list length once a word has gone through; only the count matters for steering
   function automatic int len_after(input int len, input plist_pkg::req_type w);
      int p;
      p = int'(w.position);
      case (w.opcode)
         plist_pkg::OP_INSERT: if (len < CAP && p >= 1 && p <= len + 1) return len + 1;
         plist_pkg::OP_APPEND: if (len < CAP) return len + 1;
         plist_pkg::OP_DELETE: if (p >= 1 && p <= len) return len - 1;
         default: ;
      endcase
      return len;
   endfunction

   function automatic plist_pkg::req_type pick_word(input int len);
      plist_pkg::req_type w;
      int      roll;
      int      t_ins;
      int      t_app;
      int      t_del;
      int      t_rd;
      int      limit;
      int      mode;
      roll = $urandom_range(0, 99);
      // keep the list short so walks stay cheap, but never stuck at the ends
      if (len < 8) begin
         t_ins = 30; t_app = 60; t_del = 70; t_rd = 85;
      end else if (len > 40) begin
         t_ins = 10; t_app = 20; t_del = 60; t_rd = 80;
      end else begin
         t_ins = 20; t_app = 35; t_del = 55; t_rd = 78;
      end
      if ($urandom_range(0, 99) < 3) w.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else if (roll < t_ins) w.opcode = plist_pkg::OP_INSERT;
      else if (roll < t_app) w.opcode = plist_pkg::OP_APPEND;
      else if (roll < t_del) w.opcode = plist_pkg::OP_DELETE;
      else if (roll < t_rd)  w.opcode = plist_pkg::OP_READ;
      else w.opcode = plist_pkg::OP_ROTATE;

      limit = (w.opcode == plist_pkg::OP_INSERT) ? len + 1 : len;
      mode = $urandom_range(0, 19);
      if (mode == 0) w.position = '0;
      else if (mode == 1) w.position = 11'(limit + 1);
      else if (mode == 2) w.position = 11'($urandom_range(0, 2047));
      else if (mode == 3) w.position = 11'(limit);
      else if (w.opcode == plist_pkg::OP_ROTATE) w.position = 11'($urandom_range(0, limit));
      else if (limit == 0) w.position = '0;
      else w.position = 11'($urandom_range(1, limit));

      case ($urandom_range(0, 15))
         0:       w.value = 32'sh7FFF_FFFF;
         1:       w.value = 32'sh8000_0000;
         2:       w.value = '0;
         3:       w.value = '1;
         default: w.value = plist_pkg::entry_type'($urandom);
      endcase
      w.direction = 1'($urandom_range(0, 1));
      return w;
   endfunction

   task automatic send_word(input plist_pkg::req_type w);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow_len = len_after(shadow_len, w);
      if (shadow_len > peak_len) peak_len = shadow_len;
      words_sent++;
      op_tally[w.opcode]++;
   endtask

   // hold off the sender until every word sent has been answered
   task automatic drain();
      req_valid <= 1'b0;
      while (words_checked < words_sent) @(posedge clock);
   endtask

   initial begin
      int blk;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      idle_on   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty list edge cases, then a short list with extreme values
      idle_on = 1'b1;
      send_word(make_word(plist_pkg::OP_READ,   1, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_DELETE, 1, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_ROTATE, 0, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_ROTATE, 1, 0, 1'b1));
      send_word(make_word(plist_pkg::OP_INSERT, 0, 5, 1'b0));
      send_word(make_word(plist_pkg::OP_INSERT, 2, 5, 1'b0));
      send_word(make_word(plist_pkg::OP_INSERT, 1, 32'sh7FFF_FFFF, 1'b0));
      send_word(make_word(plist_pkg::OP_APPEND, 0, 32'sh8000_0000, 1'b1));
      send_word(make_word(plist_pkg::OP_INSERT, 3, -1, 1'b0));
      send_word(make_word(plist_pkg::OP_INSERT, 1, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_INSERT, 2, 32'sh5555_5555, 1'b0));
      send_word(make_word(plist_pkg::OP_APPEND, 0, 32'shAAAA_AAAA, 1'b0));
      send_word(make_word(plist_pkg::OP_READ,   6, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_READ,   1, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_READ,   7, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_READ,   0, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_ROTATE, 2, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_ROTATE, 6, 0, 1'b1));
      send_word(make_word(plist_pkg::OP_ROTATE, 0, 0, 1'b1));
      send_word(make_word(plist_pkg::OP_ROTATE, 7, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_DELETE, 6, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_DELETE, 1, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_DELETE, 0, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_DELETE, 2047, -1, 1'b1));
      send_word(make_word(OP_SPARE_LO, 3, 7, 1'b0));
      send_word(make_word(OP_SPARE_HI, 1, -1, 1'b1));
      drain();

      // last block runs with no idling on either side
      for (blk = 0; blk < 4; blk++) begin
         idle_on = (blk != 3);
         repeat (138) send_word(pick_word(shadow_len));
         if (blk == 1) drain();
      end

      // ends of whatever list is left
      send_word(make_word(plist_pkg::OP_READ,   shadow_len, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_READ,   shadow_len + 1, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_ROTATE, shadow_len, 0, 1'b0));
      send_word(make_word(plist_pkg::OP_ROTATE, shadow_len + 1, 0, 1'b1));
      send_word(make_word(plist_pkg::OP_DELETE, shadow_len, 0, 1'b0));
      drain();
      repeat (CAP + 8) @(posedge clock);

      $display("%0d request words (%0d insert, %0d delete, %0d read, %0d append, %0d rotate)",
               words_sent, op_tally[plist_pkg::OP_INSERT], op_tally[plist_pkg::OP_DELETE],
               op_tally[plist_pkg::OP_READ], op_tally[plist_pkg::OP_APPEND],
               op_tally[plist_pkg::OP_ROTATE]);
      $display("%0d responses checked; list ran from empty up to %0d entries",
               words_checked, peak_len);
      if (fail_count == 0 && pending == 0) begin
         $display("positional_list_engine test passed");
      end else begin
         $display("positional_list_engine test failed");
      end
      $finish;
   end

endmodule
